// File: rtl/core/led_scanner_with_fading_trail_assert.svh
// Assertion macros for the scanner core; clock i_clk, reset i_rst_n.
`ifndef LED_SCANNER_WITH_FADING_TRAIL_ASSERT_SVH
`define LED_SCANNER_WITH_FADING_TRAIL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSFT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LSFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lsft_pkg.sv
package lsft_pkg;

    localparam int unsigned PIX_W     = 24;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned TW_W      = 4;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned RCP_W     = 17;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_UP,
        PH_DOWN,
        PH_END
    } t_phase;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HEAD_COLOR  = 2'd0;
    localparam t_cfg_idx CFG_TRAIL_WIDTH = 2'd1;
    localparam t_cfg_idx CFG_STEP_TICKS  = 2'd2;

    localparam logic [PIX_W-1:0]  HEAD_COLOR_RST  = 24'hFF1000;
    localparam logic [TW_W-1:0]   TRAIL_WIDTH_RST = 4'd7;
    localparam logic [TICK_W-1:0] STEP_TICKS_RST  = 16'd32;
    localparam logic [TW_W-1:0]   DIV_BASE        = 4'd10;
    localparam logic [TW_W-1:0]   TRAIL_MAX       = 4'd9;

    // ceil(2^16 / d): exact floor division of any 8-bit value by d
    function automatic logic [RCP_W-1:0] recip(input logic [TW_W-1:0] d);
        logic [RCP_W-1:0] r;
        case (d)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            4'd10:   r = 17'd6554;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] fade_chan(input logic [7:0] c, input logic [RCP_W-1:0] r);
        logic [RCP_W+7:0] p;
        p = c * r;
        return p[23:16];
    endfunction

    function automatic logic [PIX_W-1:0] fade(input logic [PIX_W-1:0] c,
                                              input logic [RCP_W-1:0] r);
        return {fade_chan(c[23:16], r), fade_chan(c[15:8], r), fade_chan(c[7:0], r)};
    endfunction

endpackage

// File: rtl/core/led_scanner_with_fading_trail.sv
// A tick that steps, starts or ends a sweep launches a frame: each entry is read from the
// store's single read port into the read stage and then the output register, one pixel a
// cycle while the pixel channel is not stalled; a tick without a step launches no frame.
// Ticks are held off until the last pixel of a frame is taken, so no new tick is accepted
// while a frame is in flight.
// Reset: synchronous, active low; the store reads as all zero via a valid flag per entry.
`include "led_scanner_with_fading_trail_assert.svh"

module led_scanner_with_fading_trail #(
    parameter int unsigned PIXEL_COUNT = 42
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_run,
    // pixel channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lsft_pkg::IDX_W-1:0]    o_pixel_index,
    output logic [lsft_pkg::PIX_W-1:0]    o_pixel_color,
    output logic                          o_frame_last,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsft_pkg::PIX_W-1:0]    i_cfg_data
);
    import lsft_pkg::*;

    localparam int unsigned     IW       = $clog2(PIXEL_COUNT);
    localparam logic [IW-1:0]   LAST_IDX = IW'(PIXEL_COUNT - 1);

    // What one frame does to the store, latched when the frame is launched
    typedef struct packed {
        logic          clear;
        logic          dir_up;
        logic [IW-1:0] head;
    } t_frame;

    // Configuration registers
    logic [PIX_W-1:0]  r_head_color;
    logic [TW_W-1:0]   r_trail_width;
    logic [TICK_W-1:0] r_step_ticks;

    // Sweep state
    t_phase            r_phase, n_phase;
    logic [IW-1:0]     r_head, n_head;
    logic [TICK_W-1:0] r_tick, n_tick;

    // Frame sequencer
    logic              r_active;
    logic [IW-1:0]     r_rd_idx;
    t_frame            r_frame, n_frame;

    // Read stage and output register
    logic              r_s1_valid;
    logic [IW-1:0]     r_s1_idx;
    logic [PIX_W-1:0]  r_rdata;
    logic              r_rvalid;
    logic              r_out_valid;
    logic [IW-1:0]     r_out_idx;
    logic [PIX_W-1:0]  r_out_color;
    logic              r_out_last;

    // Pixel store and its per-entry written flags
    logic [PIX_W-1:0]       mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] r_ent_valid;

    logic              tick_acc;
    logic              busy;
    logic              launch;
    logic              step_now;
    logic              tick_due;
    logic [TICK_W-1:0] tick_inc;
    logic [IW-1:0]     step_base;
    logic [IW-1:0]     up_head;
    logic [IW-1:0]     dn_head;
    logic              issue;
    logic              s1_move;
    logic [PIX_W-1:0]  s1_old;
    logic [PIX_W-1:0]  s1_new;
    logic              behind;
    logic [TW_W-1:0]   trail_clamp;
    logic [RCP_W-1:0]  rcp;

    // ------------------------------------------------------------------
    // Handshakes: hold off ticks while any pixel of a frame is in flight
    // ------------------------------------------------------------------
    assign busy        = r_active | r_s1_valid | r_out_valid;
    assign o_stall     = busy;
    assign tick_acc    = i_valid & ~busy;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_color  <= HEAD_COLOR_RST;
            r_trail_width <= TRAIL_WIDTH_RST;
            r_step_ticks  <= STEP_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEAD_COLOR:  r_head_color  <= i_cfg_data;
                CFG_TRAIL_WIDTH: r_trail_width <= i_cfg_data[TW_W-1:0];
                CFG_STEP_TICKS:  r_step_ticks  <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Divisor is ten minus the trail width, held at one above nine
    assign trail_clamp = (r_trail_width > TRAIL_MAX) ? TRAIL_MAX : r_trail_width;
    assign rcp         = recip(DIV_BASE - trail_clamp);

    // ------------------------------------------------------------------
    // Step decode
    // ------------------------------------------------------------------
    assign tick_inc  = r_tick + 1'b1;
    assign tick_due  = (tick_inc >= r_step_ticks);
    // A sweep always starts from pixel zero
    assign step_base = (r_phase == PH_IDLE) ? '0 : r_head;
    assign up_head   = (step_base < LAST_IDX) ? step_base + 1'b1 : step_base;
    assign dn_head   = (step_base != '0) ? step_base - 1'b1 : step_base;
    assign step_now  = tick_acc & tick_due & ((r_phase == PH_UP) | (r_phase == PH_DOWN));

    // Next sweep phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (tick_acc && i_run) n_phase = PH_UP;
            end
            PH_UP: begin
                if (step_now && up_head == LAST_IDX) n_phase = PH_DOWN;
            end
            PH_DOWN: begin
                if (step_now && dn_head == '0) n_phase = PH_END;
            end
            PH_END: begin
                if (tick_acc) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Head, tick counter and the frame to launch
    always_comb begin
        n_head  = r_head;
        n_tick  = r_tick;
        n_frame = r_frame;
        launch  = 1'b0;
        if (tick_acc) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_run) begin
                        n_tick  = '0;
                        n_head  = up_head;
                        n_frame = '{clear: 1'b0, dir_up: 1'b1, head: up_head};
                        launch  = 1'b1;
                    end
                end
                PH_UP: begin
                    n_tick = tick_due ? '0 : tick_inc;
                    if (tick_due) begin
                        n_head  = up_head;
                        n_frame = '{clear: 1'b0, dir_up: 1'b1, head: up_head};
                        launch  = 1'b1;
                    end
                end
                PH_DOWN: begin
                    n_tick = tick_due ? '0 : tick_inc;
                    if (tick_due) begin
                        n_head  = dn_head;
                        n_frame = '{clear: 1'b0, dir_up: 1'b0, head: dn_head};
                        launch  = 1'b1;
                    end
                end
                PH_END: begin
                    // all-off frame, store wiped as it is walked
                    n_tick  = '0;
                    n_head  = '0;
                    n_frame = '{clear: 1'b1, dir_up: 1'b0, head: '0};
                    launch  = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_head  <= '0;
            r_tick  <= '0;
        end else begin
            r_phase <= n_phase;
            r_head  <= n_head;
            r_tick  <= n_tick;
        end
    end

    // ------------------------------------------------------------------
    // Frame walk: read each entry, modify, write back and emit
    // ------------------------------------------------------------------
    assign s1_move = r_s1_valid & (~r_out_valid | ~i_stall);
    assign issue   = r_active & (~r_s1_valid | s1_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_rd_idx   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (launch) begin
                r_active <= 1'b1;
                r_rd_idx <= '0;
            end else if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
                if (r_rd_idx == LAST_IDX) r_active <= 1'b0;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Frame descriptor and read index tag need no reset
    always_ff @(posedge i_clk) begin
        if (launch) r_frame <= n_frame;
        if (issue)  r_s1_idx <= r_rd_idx;
    end

    // Store: one read and one write a cycle, never to the same entry
    always_ff @(posedge i_clk) begin
        if (issue) r_rdata <= mem[r_rd_idx];
        if (s1_move) mem[r_s1_idx] <= s1_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
        end else if (s1_move) begin
            r_ent_valid[r_s1_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) r_rvalid <= r_ent_valid[r_rd_idx];
    end

    // Entries never written since reset read as off
    assign s1_old = r_rvalid ? r_rdata : '0;
    assign behind = r_frame.dir_up ? (r_s1_idx < r_frame.head) : (r_s1_idx > r_frame.head);

    always_comb begin
        if (r_frame.clear) begin
            s1_new = '0;
        end else if (r_s1_idx == r_frame.head) begin
            s1_new = r_head_color;
        end else if (behind) begin
            s1_new = fade(s1_old, rcp);
        end else begin
            s1_new = s1_old;
        end
    end

    // Output register: load on a move, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_idx   <= r_s1_idx;
            r_out_color <= s1_new;
            r_out_last  <= (r_s1_idx == LAST_IDX);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_index = IDX_W'(r_out_idx);
    assign o_pixel_color = r_out_color;
    assign o_frame_last  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LSFT_ASSERT_SAME(a_last_index, o_valid && o_frame_last,
        o_pixel_index == IDX_W'(LAST_IDX), "frame_last away from the final pixel")
    `LSFT_ASSERT_NEXT(a_frame_gapless, o_valid && !i_stall && !o_frame_last,
        o_valid && (o_pixel_index == $past(o_pixel_index) + 1'b1), "gap or skip inside a frame")
    `LSFT_ASSERT_SAME(a_end_at_zero, r_phase == PH_END,
        r_head == '0, "sweep ended with the head away from pixel zero")
    `LSFT_ASSERT_SAME(a_idle_tick, r_phase == PH_IDLE,
        r_tick == '0, "tick counter running while idle")

endmodule

// File: verif/led_scanner_with_fading_trail_tb.sv
module led_scanner_with_fading_trail_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsft_pkg::*;

    localparam int PIXELS      = 42;
    localparam int SETTLE      = 4;       // settle margin for a trailing tick without a step
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_TICKS = 307;

    // Index 3 selects no register; writes to it must change nothing.
    localparam t_cfg_idx CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [PIX_W-1:0] colour;
        logic             last;
    } t_pixel;

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_run       = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [IDX_W-1:0]     o_pixel_index;
    logic [PIX_W-1:0]     o_pixel_color;
    logic                 o_frame_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index = '0;
    logic [PIX_W-1:0]     i_cfg_data  = '0;

    led_scanner_with_fading_trail dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_run         (i_run),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_index (o_pixel_index),
        .o_pixel_color (o_pixel_color),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner model: its own copy of the registers and of the strip
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  cfg_colour = HEAD_COLOR_RST;
    logic [TW_W-1:0]   cfg_trail  = TRAIL_WIDTH_RST;
    logic [TICK_W-1:0] cfg_step   = STEP_TICKS_RST;

    logic [PIX_W-1:0]  strip [PIXELS] = '{default: '0};
    logic [IDX_W-1:0]  head_pos = '0;
    t_phase            phase    = PH_IDLE;
    logic [TICK_W-1:0] tick_cnt = '0;

    t_pixel            pixel_due [$];   // pixels still owed by the block, oldest first
    bit                tick_fifo [$];   // run flags waiting to be sent

    int send_idle_pct = 30;
    int recv_idle_pct = 30;

    int faults       = 0;
    int ticks_done   = 0;
    int frames_due   = 0;
    int pixels_seen  = 0;
    int sweeps_done  = 0;
    int writes_done  = 0;
    int cycle_cnt    = 0;

    // Divide each 8-bit channel by ten minus the trail width; widths of nine and
    // above hold the divisor at one, so the trail no longer fades.
    function automatic logic [PIX_W-1:0] dim(input logic [PIX_W-1:0] c);
        int unsigned d;
        d = 10 - ((cfg_trail > 9) ? 9 : cfg_trail);
        return {8'(c[23:16] / d), 8'(c[15:8] / d), 8'(c[7:0] / d)};
    endfunction

    // Move the head one pixel, paint it and dim everything behind it.
    function automatic void move_head();
        if (phase == PH_UP) begin
            if (head_pos < PIXELS - 1)
                head_pos++;
            strip[head_pos] = cfg_colour;
            for (int x = head_pos; x > 0; x--)
                strip[x-1] = dim(strip[x-1]);
            if (head_pos >= PIXELS - 1)
                phase = PH_DOWN;
        end else begin
            if (head_pos > 0)
                head_pos--;
            strip[head_pos] = cfg_colour;
            for (int x = head_pos + 1; x < PIXELS; x++)
                strip[x] = dim(strip[x]);
            if (head_pos == 0)
                phase = PH_END;
        end
    endfunction

    // Owe the whole strip as one frame.
    function automatic void queue_frame();
        for (int i = 0; i < PIXELS; i++)
            pixel_due.push_back('{index: IDX_W'(i), colour: strip[i], last: (i == PIXELS - 1)});
        frames_due++;
    endfunction

    // Advance the model by one accepted tick.
    function automatic void predict_tick(input bit run);
        case (phase)
            PH_IDLE: begin
                // a sweep starts with a step on the very tick that sees run
                if (run) begin
                    phase    = PH_UP;
                    head_pos = '0;
                    tick_cnt = '0;
                    move_head();
                    queue_frame();
                end
            end
            PH_END: begin
                // run is ignored here; blank the strip and go idle
                strip    = '{default: '0};
                head_pos = '0;
                tick_cnt = '0;
                phase    = PH_IDLE;
                queue_frame();
                sweeps_done++;
            end
            default: begin
                // a step count of zero behaves as one
                tick_cnt++;
                if (tick_cnt >= cfg_step) begin
                    tick_cnt = '0;
                    move_head();
                    queue_frame();
                end
            end
        endcase
    endfunction

    function automatic void note_fault(input string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Tick driver: feed run flags from the queue, hold a stalled transaction,
    // and predict each one as it is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tick_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_tick(i_run);
                ticks_done++;
            end
            // only move on once the current transaction has gone
            if (!i_valid || !o_stall) begin
                if (tick_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_run   <= tick_fifo.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel monitor: stall at random and check every accepted pixel against
    // the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_monitor
        t_pixel want;
        i_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            pixels_seen++;
            if (pixel_due.size() == 0) begin
                note_fault($sformatf("unexpected pixel idx=%0d colour=%06h last=%0b",
                                     o_pixel_index, o_pixel_color, o_frame_last));
            end else begin
                want = pixel_due.pop_front();
                if (o_pixel_index !== want.index || o_pixel_color !== want.colour ||
                    o_frame_last !== want.last)
                    note_fault($sformatf({"expected idx=%0d colour=%06h last=%0b, ",
                                          "got idx=%0d colour=%06h last=%0b"},
                                         want.index, want.colour, want.last,
                                         o_pixel_index, o_pixel_color, o_frame_last));
            end
        end
    end

    // Guard against a hang.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still owed", cycle_cnt,
                     pixel_due.size());
            $display("led_scanner_with_fading_trail_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Wait until every tick has gone and every pixel has come back, then give a
    // tick without a step time to complete.
    task automatic settle_idle();
        do @(negedge i_clk);
        while (tick_fifo.size() != 0 || i_valid || pixel_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Drive one register write and wait for its handshake; leave valid high so
    // a following write can chain on the same edge.
    task automatic write_reg(input t_cfg_idx idx, input logic [PIX_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_HEAD_COLOR:  cfg_colour = data;
            CFG_TRAIL_WIDTH: cfg_trail  = data[TW_W-1:0];
            CFG_STEP_TICKS:  cfg_step   = data[TICK_W-1:0];
            default: ;
        endcase
        writes_done++;
    endtask

    // Reprogram all three registers while the block is quiet; unused upper data
    // bits carry noise to show they are dropped.
    task automatic reprogram(input logic [PIX_W-1:0] colour, input logic [TW_W-1:0] trail,
                             input logic [TICK_W-1:0] step, input bit poke_spare);
        settle_idle();
        if (poke_spare)
            write_reg(CFG_SPARE, PIX_W'($urandom));
        write_reg(CFG_TRAIL_WIDTH, {20'($urandom), trail});
        write_reg(CFG_HEAD_COLOR, colour);
        write_reg(CFG_STEP_TICKS, {8'($urandom), step});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_ticks(input int n, input int run_pct);
        for (int k = 0; k < n; k++)
            tick_fifo.push_back($urandom_range(99) < run_pct);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int n;
        int sent;
        int pick;
        int phase_no;
        logic [PIX_W-1:0]  colour;
        logic [TW_W-1:0]   trail;
        logic [TICK_W-1:0] step;

        sent     = 0;
        phase_no = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers first; idle ticks without run are dropped,
        // run starts a sweep at once, run mid-sweep is ignored.
        tick_fifo.push_back(1'b0);
        tick_fifo.push_back(1'b0);
        tick_fifo.push_back(1'b1);
        tick_fifo.push_back(1'b1);
        tick_fifo.push_back(1'b0);

        // Extremes: white head with the deepest fade, step count zero.
        reprogram(24'hFFFFFF, 4'd0, 16'd0, 1'b0);
        queue_ticks(5, 100);
        // Black head, trail width above nine (no fade), slowest step.
        reprogram(24'h000000, 4'd15, 16'hFFFF, 1'b0);
        queue_ticks(3, 50);
        // Divisor nine, one step per tick.
        reprogram(PIX_W'($urandom), 4'd1, 16'd1, 1'b0);
        queue_ticks(3, 100);
        // Width exactly nine, with a write to the unused index.
        reprogram(24'h00FF00, 4'd9, 16'd1, 1'b1);
        queue_ticks(3, 100);
        reprogram(24'hFF0000, 4'd8, 16'd2, 1'b0);
        queue_ticks(3, 100);
        reprogram(24'h0000FF, 4'd2, 16'd1, 1'b0);
        queue_ticks(3, 100);

        // Random phases: mostly short step counts so sweeps run end to end and
        // reverse, the odd long one only for a handful of ticks.
        while (sent < RANDOM_TICKS) begin
            pick = $urandom_range(9);
            colour = (pick == 0) ? 24'h000000 :
                     (pick == 1) ? 24'hFFFFFF : PIX_W'($urandom);
            trail = ($urandom_range(4) == 0) ? TW_W'($urandom) : TW_W'($urandom_range(8, 2));
            pick = $urandom_range(19);
            if (pick < 14) begin
                step = TICK_W'($urandom_range(2, 0));
                n    = $urandom_range(70, 30);
            end else if (pick < 19) begin
                step = TICK_W'($urandom_range(6, 3));
                n    = $urandom_range(50, 20);
            end else begin
                step = TICK_W'($urandom_range(65535, 7));
                n    = $urandom_range(6, 3);
            end
            // stop at the planned number of ticks
            if (n > RANDOM_TICKS - sent)
                n = RANDOM_TICKS - sent;
            reprogram(colour, trail, step, $urandom_range(9) == 0);

            // keep one long stretch free of any idling on either side
            send_idle_pct = (phase_no == 1) ? 0 : 30;
            recv_idle_pct = (phase_no == 1) ? 0 : 30;
            queue_ticks(n, 75);
            sent += n;
            phase_no++;
        end

        // Drain, then allow for a trailing tick without a step.
        settle_idle();
        if (pixel_due.size() != 0)
            note_fault($sformatf("%0d pixels never arrived", pixel_due.size()));

        $display("run covered %0d ticks, %0d register writes, %0d random phases",
                 ticks_done, writes_done, phase_no);
        $display("%0d frames (%0d pixels) checked across %0d finished sweeps, %0d faults",
                 frames_due, pixels_seen, sweeps_done, faults);
        if (faults == 0)
            $display("led_scanner_with_fading_trail_tb OK");
        else
            $display("led_scanner_with_fading_trail_tb NOT OK");
        $finish;
    end

endmodule
